// ===== design/tfp_pkg.sv =====
// Shared package for the text-to-fixed-point parser.
// Holds field widths, character codes, register indexes, state types and the digit decoder.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tfp_pkg;

	// Field and state widths.
	localparam int CODE_W     = 16;
	localparam int BASE_W     = 5;
	localparam int DIGIT_W    = 4;
	localparam int INT_W      = 23;
	localparam int FRAC_W     = 24;
	localparam int SCALE_W    = 25;
	localparam int CNT_W      = 4;
	localparam int FRAC_BITS  = 12;
	localparam int VALUE_W    = 36;
	localparam int MAC_W      = SCALE_W + BASE_W;
	localparam int QCNT_W     = $clog2(FRAC_BITS);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// Fraction digits beyond this count are consumed but ignored.
	localparam int MAX_FRACTION_DIGITS = 6;

	// Character codes.
	localparam logic [CODE_W-1:0] CODE_POINT = 16'hFF0E;
	localparam logic [CODE_W-1:0] CODE_MINUS = 16'hFF0D;
	localparam logic [CODE_W-1:0] CODE_DIG0  = 16'hFF10;
	localparam logic [CODE_W-1:0] CODE_DIG9  = 16'hFF19;
	localparam logic [CODE_W-1:0] CODE_LETA  = 16'hFF21;
	localparam logic [CODE_W-1:0] CODE_LETF  = 16'hFF26;

	// Integer part stops growing once it reaches this value.
	localparam logic [INT_W-1:0] INT_STOP_LIMIT = 23'd524288;

	localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
	localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUMBER_BASE = 1'b0,
		REG_ALLOW_POINT = 1'b1
	} cfg_reg_t;

	// Parse phase of the current string.
	typedef enum logic [1:0] {
		PH_INT,
		PH_FRAC,
		PH_STOP
	} phase_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_SCALE,
		ST_DIV,
		ST_FIN
	} seq_state_t;

	// Decoded character: digit flag and digit value.
	typedef struct packed {
		logic               is_digit;
		logic [DIGIT_W-1:0] value;
	} digit_t;

	// Map a full-width character code to a digit value, if it is one.
	function automatic digit_t decode_digit(logic [CODE_W-1:0] code);
		digit_t r;
		r.is_digit = 1'b0;
		r.value    = '0;
		if (code >= CODE_DIG0 && code <= CODE_DIG9) begin
			r.is_digit = 1'b1;
			r.value    = DIGIT_W'(code - CODE_DIG0);
		end else if (code >= CODE_LETA && code <= CODE_LETF) begin
			r.is_digit = 1'b1;
			r.value    = DIGIT_W'(code - CODE_LETA + 16'd10);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/tfp_if.sv =====
// Stream interfaces of the text-to-fixed-point parser: character input and value output.
// Depends on tfp_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface tfp_char_if;
	logic                       valid;
	logic                       ready;
	logic [tfp_pkg::CODE_W-1:0] char_code;
	logic                       is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface tfp_value_if;
	logic                               valid;
	logic                               ready;
	logic signed [tfp_pkg::VALUE_W-1:0] fixed_value;

	modport source (output valid, output fixed_value, input ready);
	modport sink (input valid, input fixed_value, output ready);
endinterface

`default_nettype wire

// ===== design/tfp_mac.sv =====
// Shared multiply-add unit: y = a * b + c, used for the integer, fraction and scale updates.
// Depends on tfp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module tfp_mac (
	input  wire logic [tfp_pkg::SCALE_W-1:0] a,
	input  wire logic [tfp_pkg::BASE_W-1:0]  b,
	input  wire logic [tfp_pkg::DIGIT_W-1:0] c,
	output logic      [tfp_pkg::MAC_W-1:0]   y
);

	// The radix is at most 16, so this is a narrow 25 x 5 product.
	assign y = tfp_pkg::MAC_W'(a) * tfp_pkg::MAC_W'(b) + tfp_pkg::MAC_W'(c);

endmodule

`default_nettype wire

// ===== design/tfp_div.sv =====
// Restoring divider for the fraction: quotient = (fraction * 4096) / scale, one bit per cycle.
// Depends on tfp_pkg; the divisor is held stable by the caller while it runs.
`timescale 1ns / 1ps
`default_nettype none

module tfp_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [tfp_pkg::FRAC_W-1:0]    dividend,
	input  wire logic [tfp_pkg::SCALE_W-1:0]   divisor,
	output logic                               done,
	output logic      [tfp_pkg::FRAC_BITS-1:0] quotient
);

	logic                            busy_q;
	logic                            done_q;
	logic [tfp_pkg::QCNT_W-1:0]      cnt_q;
	logic [tfp_pkg::SCALE_W-1:0]     rem_q;
	logic [tfp_pkg::FRAC_BITS-1:0]   quo_q;
	logic [tfp_pkg::SCALE_W:0]       rem_shift;
	logic [tfp_pkg::SCALE_W:0]       rem_diff;
	logic                            fits;

	// One compare-subtract step; the remainder stays below the divisor when the dividend starts below it.
	always_comb begin
		rem_shift = {rem_q, 1'b0};
		fits      = rem_shift >= {1'b0, divisor};
		rem_diff  = rem_shift - {1'b0, divisor};
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == tfp_pkg::QCNT_W'(tfp_pkg::FRAC_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= tfp_pkg::SCALE_W'(dividend);
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[tfp_pkg::SCALE_W-1:0] : rem_shift[tfp_pkg::SCALE_W-1:0];
			quo_q <= {quo_q[tfp_pkg::FRAC_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== design/text_to_fixed_point_parser.sv =====
// Text-to-fixed-point parser: turns a string of full-width characters into a signed 24.12 value.
// Depends on tfp_pkg, tfp_if, tfp_mac and tfp_div.
//
// One character is taken at a time; the input is not ready while a character is being worked on.
// A character is accepted in the idle state and then makes one pass through the shared
// multiply-add unit; a fraction digit within the digit limit makes a second pass, for the scale.
// After the character marked last, the bit-per-cycle fraction divider works out the quotient,
// the sequencer waits for its done flag, and the output register is loaded once its previous
// word has been taken. Only the last character of a string produces a word, and parsing state
// returns to its initial values afterwards; register settings are kept.
`timescale 1ns / 1ps
`default_nettype none

module text_to_fixed_point_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	tfp_char_if.sink                             char_in,
	tfp_value_if.source                          value_out
);

	tfp_pkg::seq_state_t             state_q, state_d;
	tfp_pkg::phase_t                 phase_q, phase_d;
	logic [tfp_pkg::CODE_W-1:0]      code_q, code_d;
	logic                            last_q, last_d;
	logic                            first_q, first_d;
	logic                            neg_q, neg_d;
	logic [tfp_pkg::INT_W-1:0]       int_acc_q, int_acc_d;
	logic [tfp_pkg::FRAC_W-1:0]      frac_acc_q, frac_acc_d;
	logic [tfp_pkg::SCALE_W-1:0]     scale_q, scale_d;
	logic [tfp_pkg::CNT_W-1:0]       count_q, count_d;
	logic                            out_valid_q, out_valid_d;
	logic [tfp_pkg::VALUE_W-1:0]     out_value_q, out_value_d;
	logic [tfp_pkg::BASE_W-1:0]      number_base_q;
	logic                            allow_point_q;

	logic [tfp_pkg::BASE_W-1:0]      eff_base;
	tfp_pkg::digit_t                 dig;
	logic                            digit_ok;
	logic                            step_scale;
	logic [tfp_pkg::SCALE_W-1:0]     mac_a;
	logic [tfp_pkg::DIGIT_W-1:0]     mac_c;
	logic [tfp_pkg::MAC_W-1:0]       mac_y;
	logic                            div_start;
	logic                            div_done;
	logic [tfp_pkg::FRAC_BITS-1:0]   div_quotient;
	logic [tfp_pkg::VALUE_W-1:0]     magnitude;

	// Shared multiply-add unit.
	tfp_mac u_mac (
		.a (mac_a),
		.b (eff_base),
		.c (mac_c),
		.y (mac_y)
	);

	// Fraction divider.
	tfp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (frac_acc_q),
		.divisor  (scale_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Radix clamp and digit classification of the held character.
	always_comb begin
		eff_base  = (number_base_q > tfp_pkg::BASE_MAX) ? tfp_pkg::BASE_MAX : number_base_q;
		dig       = tfp_pkg::decode_digit(code_q);
		digit_ok  = dig.is_digit && ({1'b0, dig.value} < eff_base);
		magnitude = {1'b0, int_acc_q, div_quotient};
	end

	// Sequencer: next state, datapath selects and state updates.
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		code_d      = code_q;
		last_d      = last_q;
		first_d     = first_q;
		neg_d       = neg_q;
		int_acc_d   = int_acc_q;
		frac_acc_d  = frac_acc_q;
		scale_d     = scale_q;
		count_d     = count_q;
		out_value_d = out_value_q;
		out_valid_d = out_valid_q;
		mac_a       = '0;
		mac_c       = '0;
		div_start   = 1'b0;
		step_scale  = 1'b0;

		if (out_valid_q && value_out.ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			tfp_pkg::ST_IDLE: begin
				if (char_in.valid) begin
					code_d  = char_in.char_code;
					last_d  = char_in.is_last;
					state_d = tfp_pkg::ST_STEP;
				end
			end
			tfp_pkg::ST_STEP: begin
				first_d = 1'b0;
				unique case (phase_q)
					tfp_pkg::PH_INT: begin
						if (digit_ok) begin
							mac_a     = tfp_pkg::SCALE_W'(int_acc_q);
							mac_c     = dig.value;
							int_acc_d = mac_y[tfp_pkg::INT_W-1:0];
							if (mac_y >= tfp_pkg::MAC_W'(tfp_pkg::INT_STOP_LIMIT)) begin
								phase_d = tfp_pkg::PH_STOP;
							end
						end else if (code_q == tfp_pkg::CODE_POINT && allow_point_q) begin
							phase_d = tfp_pkg::PH_FRAC;
						end else if (first_q && code_q == tfp_pkg::CODE_MINUS) begin
							neg_d = 1'b1;
						end else begin
							phase_d = tfp_pkg::PH_STOP;
						end
					end
					tfp_pkg::PH_FRAC: begin
						if (digit_ok) begin
							if (count_q < tfp_pkg::CNT_W'(tfp_pkg::MAX_FRACTION_DIGITS)) begin
								mac_a      = tfp_pkg::SCALE_W'(frac_acc_q);
								mac_c      = dig.value;
								frac_acc_d = mac_y[tfp_pkg::FRAC_W-1:0];
								count_d    = count_q + 1'b1;
								step_scale = 1'b1;
							end
						end else begin
							phase_d = tfp_pkg::PH_STOP;
						end
					end
					default: begin
						// Stopped: characters are ignored until the last one.
					end
				endcase
				if (step_scale) begin
					state_d = tfp_pkg::ST_SCALE;
				end else if (last_q) begin
					state_d   = tfp_pkg::ST_DIV;
					div_start = 1'b1;
				end else begin
					state_d = tfp_pkg::ST_IDLE;
				end
			end
			tfp_pkg::ST_SCALE: begin
				mac_a   = scale_q;
				scale_d = mac_y[tfp_pkg::SCALE_W-1:0];
				if (last_q) begin
					state_d   = tfp_pkg::ST_DIV;
					div_start = 1'b1;
				end else begin
					state_d = tfp_pkg::ST_IDLE;
				end
			end
			tfp_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = tfp_pkg::ST_FIN;
				end
			end
			tfp_pkg::ST_FIN: begin
				// Load the output word once the register is free, then start a new string.
				if (!out_valid_q || value_out.ready) begin
					out_valid_d = 1'b1;
					out_value_d = neg_q ? (tfp_pkg::VALUE_W'(0) - magnitude) : magnitude;
					phase_d     = tfp_pkg::PH_INT;
					first_d     = 1'b1;
					neg_d       = 1'b0;
					int_acc_d   = '0;
					frac_acc_d  = '0;
					scale_d     = tfp_pkg::SCALE_W'(1);
					count_d     = '0;
					state_d     = tfp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tfp_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Parse state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= tfp_pkg::PH_INT;
			first_q     <= 1'b1;
			neg_q       <= 1'b0;
			int_acc_q   <= '0;
			frac_acc_q  <= '0;
			scale_q     <= tfp_pkg::SCALE_W'(1);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			first_q     <= first_d;
			neg_q       <= neg_d;
			int_acc_q   <= int_acc_d;
			frac_acc_q  <= frac_acc_d;
			scale_q     <= scale_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Held character and output word.
	always_ff @(posedge clk) begin
		code_q      <= code_d;
		last_q      <= last_d;
		out_value_q <= out_value_d;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= tfp_pkg::BASE_RESET;
			allow_point_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (tfp_pkg::cfg_reg_t'(cfg_index))
				tfp_pkg::REG_NUMBER_BASE: number_base_q <= cfg_data;
				tfp_pkg::REG_ALLOW_POINT: allow_point_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign char_in.ready         = (state_q == tfp_pkg::ST_IDLE);
	assign value_out.valid       = out_valid_q;
	assign value_out.fixed_value = $signed(out_value_q);

endmodule

`default_nettype wire

// ===== design/tfp_checker.sv =====
// Port-level checks for the text-to-fixed-point parser, bound to its top level.
// Depends on tfp_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

module tfp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        in_last,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [tfp_pkg::VALUE_W-1:0] fixed_value
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// A stalled output word stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fixed_value))
		else $error("output word changed or dropped while stalled");

	// The parser works on one character at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input ready right after a character was accepted");

	// A new output word appears together with the input reopening for the next string.
	a_word_reopens_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $rose(in_ready))
		else $error("output word loaded without returning to idle");

	// After a character that does not end a string, the input becomes ready again.
	a_char_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !in_last |-> ##3 (in_ready || $past(in_ready)))
		else $error("non-final character took too long");

endmodule

bind text_to_fixed_point_parser tfp_checker u_tfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (char_in.valid),
	.in_ready    (char_in.ready),
	.in_last     (char_in.is_last),
	.out_valid   (value_out.valid),
	.out_ready   (value_out.ready),
	.fixed_value (value_out.fixed_value)
);

`default_nettype wire
